/* rtl/core/cpv_pkg.sv */
// Shared types, widths, constants and the arctangent table for the circular path velocity block.
// No dependencies; every other file of the block uses it through scoped names.
package cpv_pkg;

    // Sizing of the CORDIC engines and of the position inputs.
    localparam int CORDIC_STEPS = 16;
    localparam int POS_BITS     = 24;
    localparam int ATAN_LEN     = 24;
    localparam int NSTEP        = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    // Fixed widths of the registers and fields.
    localparam int RAD_W  = 22;
    localparam int CEN_W  = 24;
    localparam int AXIS_W = 2;
    localparam int VEL_W  = 19;
    localparam int ANG_W  = 16;
    localparam int GUARD  = 8;

    // Vectoring path widths.
    localparam int DX_W   = ((POS_BITS > CEN_W) ? POS_BITS : CEN_W) + 1;
    localparam int VX_W   = DX_W + GUARD + 3;
    localparam int LEN_W  = VX_W - GUARD;
    localparam int DIFF_W = LEN_W + 1;

    // Correction path widths.
    localparam int TURN_W = 26;
    localparam int NUM_W  = DIFF_W + TURN_W + 1;
    localparam int DIVD_W = NUM_W - 12;

    // Rotation and output path widths.
    localparam int RZ_W   = ANG_W + 2;
    localparam int RX_W   = RAD_W + GUARD + 3;
    localparam int X0P_W  = RAD_W + 24;
    localparam int V_W    = RX_W + 1;
    localparam int A_W    = V_W - 10;
    localparam int RCP_W  = 20;
    localparam int P_W    = A_W + RCP_W;

    // Arithmetic constants.
    localparam logic [23:0]       INV_GAIN_Q24    = 24'd10187607;
    localparam logic [TURN_W-1:0] TURN_PER_RAD    = 26'd42722830;
    localparam logic [RCP_W-1:0]  RECIP5_Q22      = 20'd838861;
    localparam logic [ANG_W-1:0]  HALF_TURN       = 16'h8000;
    localparam int                QUARTER_TURN    = 16384;

    // Axis selector codes.
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_RADIUS   = 2'd0;
    localparam logic [1:0] REG_CENTRE_X = 2'd1;
    localparam logic [1:0] REG_CENTRE_Y = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [RAD_W-1:0] RADIUS_RST = 22'd100000;
    localparam logic [CEN_W-1:0] CENTRE_RST = 24'd300000;

    // Control that travels with every pipeline stage.
    typedef struct packed {
        logic              vld;
        logic [AXIS_W-1:0] axis;
    } t_ctl;

    // Arctangent of 2^-i in binary angle units.
    function automatic logic [ANG_W-1:0] atan_units(input int idx);
        logic [ANG_W-1:0] a;
        case (idx)
            0:       a = 16'd8192;
            1:       a = 16'd4836;
            2:       a = 16'd2555;
            3:       a = 16'd1297;
            4:       a = 16'd651;
            5:       a = 16'd326;
            6:       a = 16'd163;
            7:       a = 16'd81;
            8:       a = 16'd41;
            9:       a = 16'd20;
            10:      a = 16'd10;
            11:      a = 16'd5;
            12:      a = 16'd3;
            13:      a = 16'd1;
            14:      a = 16'd1;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

endpackage

/* rtl/core/cpv_vector.sv */
// Offset from the centre, CORDIC vectoring for angle and length, and the radial error.
// Depends on cpv_pkg.
module cpv_vector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  cpv_pkg::t_ctl                     i_ctl,
    input  logic signed [cpv_pkg::POS_BITS-1:0] i_pos_x,
    input  logic signed [cpv_pkg::POS_BITS-1:0] i_pos_y,
    input  logic signed [cpv_pkg::CEN_W-1:0]  i_centre_x,
    input  logic signed [cpv_pkg::CEN_W-1:0]  i_centre_y,
    input  logic [cpv_pkg::RAD_W-1:0]         i_radius,
    output cpv_pkg::t_ctl                     o_ctl,
    output logic [cpv_pkg::ANG_W-1:0]         o_angle,
    output logic signed [cpv_pkg::DIFF_W-1:0] o_diff
);

    localparam int N  = cpv_pkg::NSTEP;
    localparam int VW = cpv_pkg::VX_W;
    localparam int LW = cpv_pkg::LEN_W;

    logic signed [VW-1:0]             r_x    [0:N];
    logic signed [VW-1:0]             r_y    [0:N];
    logic [cpv_pkg::ANG_W-1:0]        r_z    [0:N];
    logic                             r_zero [0:N];
    cpv_pkg::t_ctl                    r_ctl  [0:N];

    logic signed [cpv_pkg::DX_W-1:0]  dx;
    logic signed [cpv_pkg::DX_W-1:0]  dy;
    logic signed [VW-1:0]             n_x0;
    logic signed [VW-1:0]             n_y0;

    logic [LW+23:0]                   r_lprod;
    logic [cpv_pkg::ANG_W-1:0]        r_lz;
    logic                             r_lzero;
    cpv_pkg::t_ctl                    r_lctl;

    logic [LW+23:0]                   n_lround;
    logic [LW-1:0]                    n_len;

    // Offset from the centre, folded into the right half plane.
    always_comb begin
        dx = cpv_pkg::DX_W'(i_pos_x) - cpv_pkg::DX_W'(i_centre_x);
        dy = cpv_pkg::DX_W'(i_pos_y) - cpv_pkg::DX_W'(i_centre_y);
        if (dx[cpv_pkg::DX_W-1]) begin
            n_x0 = VW'(-dx) <<< cpv_pkg::GUARD;
            n_y0 = VW'(-dy) <<< cpv_pkg::GUARD;
        end else begin
            n_x0 = VW'(dx) <<< cpv_pkg::GUARD;
            n_y0 = VW'(dy) <<< cpv_pkg::GUARD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= dx[cpv_pkg::DX_W-1] ? cpv_pkg::HALF_TURN : '0;
            r_zero[0] <= (dx == '0) && (dy == '0);
        end
    end

    // One vectoring micro-rotation per stage.
    for (genvar k = 0; k < N; k++) begin : g_vec
        logic signed [VW-1:0]      xs;
        logic signed [VW-1:0]      ys;
        logic signed [VW-1:0]      nx;
        logic signed [VW-1:0]      ny;
        logic [cpv_pkg::ANG_W-1:0] nz;

        always_comb begin
            xs = r_x[k] >>> k;
            ys = r_y[k] >>> k;
            if (!r_y[k][VW-1]) begin
                nx = r_x[k] + ys;
                ny = r_y[k] - xs;
                nz = r_z[k] + cpv_pkg::atan_units(k);
            end else begin
                nx = r_x[k] - ys;
                ny = r_y[k] + xs;
                nz = r_z[k] - cpv_pkg::atan_units(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1] <= '0;
            end else if (i_en) begin
                r_ctl[k+1] <= r_ctl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= nx;
                r_y[k+1]    <= ny;
                r_z[k+1]    <= nz;
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    // Length: remove the guard bits and the CORDIC gain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lctl <= '0;
        end else if (i_en) begin
            r_lctl <= r_ctl[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lprod <= r_x[N][VW-1:cpv_pkg::GUARD] * cpv_pkg::INV_GAIN_Q24;
            r_lz    <= r_zero[N] ? '0 : r_z[N];
            r_lzero <= r_zero[N];
        end
    end

    // Rounded length and radial error.
    always_comb begin
        n_lround = r_lprod + (LW+24)'(24'h800000);
        n_len    = r_lzero ? '0 : n_lround[LW+23:24];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= r_lctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= r_lz;
            o_diff  <= $signed({1'b0, n_len}) - $signed(cpv_pkg::DIFF_W'(i_radius));
        end
    end

endmodule

/* rtl/core/cpv_corr.sv */
// Angle correction from the radial error: scale, pipelined restoring divide by the radius,
// then the target angle folded into the right half plane. Depends on cpv_pkg.
module cpv_corr (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  cpv_pkg::t_ctl                     i_ctl,
    input  logic [cpv_pkg::ANG_W-1:0]         i_angle,
    input  logic signed [cpv_pkg::DIFF_W-1:0] i_diff,
    input  logic [cpv_pkg::RAD_W-1:0]         i_radius,
    output cpv_pkg::t_ctl                     o_ctl,
    output logic signed [cpv_pkg::RZ_W-1:0]   o_rz,
    output logic                              o_neg
);

    localparam int DW = cpv_pkg::DIVD_W;
    localparam int RW = cpv_pkg::RAD_W;
    localparam int AW = cpv_pkg::ANG_W;
    localparam int NW = cpv_pkg::NUM_W;

    logic signed [NW-1:0]  r_num;
    logic [AW-1:0]         r_mz;
    cpv_pkg::t_ctl         r_mctl;

    logic [NW-1:0]         n_mag;

    logic [RW-1:0]         r_rem [0:DW];
    logic [DW-1:0]         r_dvd [0:DW];
    logic [AW-1:0]         r_q   [0:DW];
    logic [AW-1:0]         r_z   [0:DW];
    logic                  r_sgn [0:DW];
    cpv_pkg::t_ctl         r_ctl [0:DW];

    logic [AW-1:0]         n_qs;
    logic [AW-1:0]         n_phi;
    logic signed [cpv_pkg::RZ_W-1:0] n_zs;
    logic signed [cpv_pkg::RZ_W-1:0] n_rz;
    logic                  n_neg;

    // Radial error times turns per radian.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mctl <= '0;
        end else if (i_en) begin
            r_mctl <= i_ctl;
        end
    end

    // The product is formed at the full numerator width.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= i_diff * $signed({1'b0, cpv_pkg::TURN_PER_RAD});
            r_mz  <= i_angle;
        end
    end

    // Magnitude; the divide by 4096 is taken out as a shift.
    always_comb begin
        n_mag = r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else if (i_en) begin
            r_ctl[0] <= r_mctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_dvd[0] <= n_mag[NW-1:12];
            r_q[0]   <= '0;
            r_z[0]   <= r_mz;
            r_sgn[0] <= r_num[NW-1];
        end
    end

    // One quotient bit per stage; only the low angle bits of the quotient are kept.
    for (genvar k = 0; k < DW; k++) begin : g_div
        logic [RW:0]   t;
        logic          ge;
        logic [RW-1:0] nrem;
        logic [RW:0]   tsub;

        always_comb begin
            t    = {r_rem[k], r_dvd[k][DW-1]};
            ge   = (t >= {1'b0, i_radius});
            tsub = t - {1'b0, i_radius};
            nrem = ge ? tsub[RW-1:0] : t[RW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1] <= '0;
            end else if (i_en) begin
                r_ctl[k+1] <= r_ctl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= nrem;
                r_dvd[k+1] <= {r_dvd[k][DW-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][AW-2:0], ge};
                r_z[k+1]   <= r_z[k];
                r_sgn[k+1] <= r_sgn[k];
            end
        end
    end

    // Target angle, folded so the rotation stays within a quarter turn.
    always_comb begin
        n_qs  = r_sgn[DW] ? AW'(-r_q[DW]) : r_q[DW];
        n_phi = r_z[DW] + n_qs;
        n_zs  = cpv_pkg::RZ_W'($signed(n_phi));
        n_rz  = n_zs;
        n_neg = 1'b0;
        if (n_zs > cpv_pkg::RZ_W'(cpv_pkg::QUARTER_TURN)) begin
            n_rz  = n_zs - cpv_pkg::RZ_W'(2 * cpv_pkg::QUARTER_TURN);
            n_neg = 1'b1;
        end else if (n_zs < -cpv_pkg::RZ_W'(cpv_pkg::QUARTER_TURN)) begin
            n_rz  = n_zs + cpv_pkg::RZ_W'(2 * cpv_pkg::QUARTER_TURN);
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= r_ctl[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rz  <= n_rz;
            o_neg <= n_neg;
        end
    end

endmodule

/* rtl/core/cpv_rotate.sv */
// CORDIC rotation of the scaled radius to the target angle, axis selection and
// the truncating divide by 5120 that forms the velocity command. Depends on cpv_pkg.
module cpv_rotate (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  cpv_pkg::t_ctl                     i_ctl,
    input  logic signed [cpv_pkg::RZ_W-1:0]   i_rz,
    input  logic                              i_neg,
    input  logic signed [cpv_pkg::RX_W-1:0]   i_x0,
    output cpv_pkg::t_ctl                     o_ctl,
    output logic [cpv_pkg::VEL_W-1:0]         o_vel
);

    localparam int N  = cpv_pkg::NSTEP;
    localparam int XW = cpv_pkg::RX_W;
    localparam int ZW = cpv_pkg::RZ_W;
    localparam int VW = cpv_pkg::V_W;

    logic signed [XW-1:0] r_x   [1:N];
    logic signed [XW-1:0] r_y   [1:N];
    logic signed [ZW-1:0] r_z   [1:N];
    logic                 r_neg [1:N];
    cpv_pkg::t_ctl        r_ctl [1:N];

    logic signed [VW-1:0] n_v;
    logic [VW-1:0]        n_mag;
    logic [cpv_pkg::A_W-1:0] r_a;
    logic                 r_asgn;
    cpv_pkg::t_ctl        r_actl;

    logic [cpv_pkg::P_W-1:0] r_p;
    logic                 r_psgn;
    cpv_pkg::t_ctl        r_pctl;

    logic [cpv_pkg::VEL_W-1:0] n_q;
    logic [cpv_pkg::VEL_W-1:0] n_vel;

    // One rotation micro-step per stage; the first starts from the radius on the x axis.
    for (genvar k = 0; k < N; k++) begin : g_rot
        logic signed [XW-1:0] cx;
        logic signed [XW-1:0] cy;
        logic signed [ZW-1:0] cz;
        logic                 cneg;
        cpv_pkg::t_ctl        cctl;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [XW-1:0] nx;
        logic signed [XW-1:0] ny;
        logic signed [ZW-1:0] nz;

        if (k == 0) begin : g_first
            always_comb begin
                cx   = i_x0;
                cy   = '0;
                cz   = i_rz;
                cneg = i_neg;
                cctl = i_ctl;
            end
        end else begin : g_next
            always_comb begin
                cx   = r_x[k];
                cy   = r_y[k];
                cz   = r_z[k];
                cneg = r_neg[k];
                cctl = r_ctl[k];
            end
        end

        always_comb begin
            xs = cx >>> k;
            ys = cy >>> k;
            if (!cz[ZW-1]) begin
                nx = cx - ys;
                ny = cy + xs;
                nz = cz - ZW'(cpv_pkg::atan_units(k));
            end else begin
                nx = cx + ys;
                ny = cy - xs;
                nz = cz + ZW'(cpv_pkg::atan_units(k));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1] <= '0;
            end else if (i_en) begin
                r_ctl[k+1] <= cctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]   <= nx;
                r_y[k+1]   <= ny;
                r_z[k+1]   <= nz;
                r_neg[k+1] <= cneg;
            end
        end
    end

    // Pick cosine or negated sine, undo the half-turn fold, and take the magnitude / 1024.
    always_comb begin
        if (r_ctl[N].axis == cpv_pkg::AXIS_X) begin
            n_v = -VW'(r_y[N]);
        end else begin
            n_v = VW'(r_x[N]);
        end
        if (r_neg[N]) begin
            n_v = -n_v;
        end
        n_mag = n_v[VW-1] ? VW'(-n_v) : VW'(n_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_actl <= '0;
            r_pctl <= '0;
            o_ctl  <= '0;
        end else if (i_en) begin
            r_actl <= r_ctl[N];
            r_pctl <= r_actl;
            o_ctl  <= r_pctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= n_mag[VW-1:10];
            r_asgn <= n_v[VW-1];
            r_p    <= r_a * cpv_pkg::RECIP5_Q22;
            r_psgn <= r_asgn;
        end
    end

    // Divide by five through the reciprocal, restore the sign, zero for other axes.
    always_comb begin
        n_q = r_p[cpv_pkg::VEL_W+21:22];
        if (r_pctl.axis != cpv_pkg::AXIS_X && r_pctl.axis != cpv_pkg::AXIS_Y) begin
            n_vel = '0;
        end else if (r_psgn) begin
            n_vel = -n_q;
        end else begin
            n_vel = n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_vel <= n_vel;
        end
    end

endmodule

/* rtl/core/circular_path_velocity.sv */
// Circle-tracking velocity generator: offset angle and length by CORDIC vectoring, radial
// correction through a pipelined divider, CORDIC rotation and scaling by 1/20.
// The pipeline has 19 vectoring, 47 correction and divider, and 19 rotation and scaling
// stages. One transaction per cycle is taken; a stalled output holds the whole pipeline.
// Synchronous reset clears all valid bits and loads the register reset values; no
// clearing pass is needed. Depends on cpv_pkg and the cpv_ modules.
module circular_path_velocity (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [23:0] pos_x, [47:24] pos_y
    input  logic [1:0]  s_axis_tuser,   // [1:0] which_axis
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [18:0] velocity_cmd, [23:19] zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [cpv_pkg::RAD_W-1:0]          r_radius;
    logic signed [cpv_pkg::CEN_W-1:0]   r_centre_x;
    logic signed [cpv_pkg::CEN_W-1:0]   r_centre_y;
    logic [cpv_pkg::RAD_W-1:0]          r_rad_eff;
    logic [cpv_pkg::X0P_W-1:0]          r_x0p;
    logic signed [cpv_pkg::RX_W-1:0]    r_x0;
    logic [cpv_pkg::X0P_W-1:0]          n_x0r;

    logic                               en;
    logic                               cfg_wr;
    cpv_pkg::t_ctl                      in_ctl;
    cpv_pkg::t_ctl                      vec_ctl;
    cpv_pkg::t_ctl                      cor_ctl;
    cpv_pkg::t_ctl                      out_ctl;
    logic [cpv_pkg::ANG_W-1:0]          vec_angle;
    logic signed [cpv_pkg::DIFF_W-1:0]  vec_diff;
    logic signed [cpv_pkg::RZ_W-1:0]    cor_rz;
    logic                               cor_neg;
    logic [cpv_pkg::VEL_W-1:0]          out_vel;

    // Register writes and reads.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= cpv_pkg::RADIUS_RST;
            r_centre_x <= cpv_pkg::CENTRE_RST;
            r_centre_y <= cpv_pkg::CENTRE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                cpv_pkg::REG_RADIUS:   r_radius   <= pwdata[cpv_pkg::RAD_W-1:0];
                cpv_pkg::REG_CENTRE_X: r_centre_x <= pwdata[cpv_pkg::CEN_W-1:0];
                cpv_pkg::REG_CENTRE_Y: r_centre_y <= pwdata[cpv_pkg::CEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            cpv_pkg::REG_RADIUS:   prdata = 32'(r_radius);
            cpv_pkg::REG_CENTRE_X: prdata = 32'(unsigned'(r_centre_x));
            cpv_pkg::REG_CENTRE_Y: prdata = 32'(unsigned'(r_centre_y));
            default:               prdata = '0;
        endcase
    end

    // Values derived from the radius: a zero radius acts as one; gain-compensated start.
    assign n_x0r = r_x0p + cpv_pkg::X0P_W'(16'h8000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad_eff <= cpv_pkg::RADIUS_RST;
        end else begin
            r_rad_eff <= (r_radius == '0) ? cpv_pkg::RAD_W'(1) : r_radius;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0p <= r_rad_eff * cpv_pkg::INV_GAIN_Q24;
        r_x0  <= cpv_pkg::RX_W'(n_x0r[cpv_pkg::X0P_W-1:16]);
    end

    // Whole pipeline advances unless a result is waiting to be taken; no input during reset.
    assign en            = !out_ctl.vld || m_axis_tready;
    assign s_axis_tready = en && i_rst_n;
    assign in_ctl.vld    = s_axis_tvalid;
    assign in_ctl.axis   = s_axis_tuser;

    cpv_vector u_vector (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_ctl      (in_ctl),
        .i_pos_x    (s_axis_tdata[23:0]),
        .i_pos_y    (s_axis_tdata[47:24]),
        .i_centre_x (r_centre_x),
        .i_centre_y (r_centre_y),
        .i_radius   (r_rad_eff),
        .o_ctl      (vec_ctl),
        .o_angle    (vec_angle),
        .o_diff     (vec_diff)
    );

    cpv_corr u_corr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (vec_ctl),
        .i_angle  (vec_angle),
        .i_diff   (vec_diff),
        .i_radius (r_rad_eff),
        .o_ctl    (cor_ctl),
        .o_rz     (cor_rz),
        .o_neg    (cor_neg)
    );

    cpv_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (cor_ctl),
        .i_rz    (cor_rz),
        .i_neg   (cor_neg),
        .i_x0    (r_x0),
        .o_ctl   (out_ctl),
        .o_vel   (out_vel)
    );

    assign m_axis_tvalid = out_ctl.vld;
    assign m_axis_tdata  = {5'b0, out_vel};

    // A reset leaves no result behind.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // The command never leaves the range that the radius scaling allows.
    a_vel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(out_vel) <= 19'sd209716 && $signed(out_vel) >= -19'sd209716))
        else $error("velocity command out of range");

    // The effective radius used by the divider is never zero.
    a_radius_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_rad_eff != '0))
        else $error("zero divisor in radial correction");

    // Other axes always get a zero command.
    a_other_axis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_ctl.axis != cpv_pkg::AXIS_X && out_ctl.axis != cpv_pkg::AXIS_Y)
        |-> (out_vel == '0))
        else $error("nonzero command for an unused axis");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for circular_path_velocity: stream stimulus, APB register setup,
// an in-bench fixed-point predictor of the circle velocity command and an in-order scoreboard.
// Depends on cpv_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_ITEMS   = 1100;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Directed rows: positions, axis, and a typed-in command where obvious.
    typedef struct {
        logic [23:0] px;
        logic [23:0] py;
        logic [1:0]  axis;
        bit          fixed;
        logic [18:0] cmd;
    } t_row;

    // Model copy of the configuration registers.
    logic [cpv_pkg::RAD_W-1:0] radius_q;
    logic [cpv_pkg::CEN_W-1:0] cen_x_q;
    logic [cpv_pkg::CEN_W-1:0] cen_y_q;

    logic [18:0] exp_cmds[$];
    int          errors;
    int          n_sent;
    int          n_checked;
    int          idle_count;
    int          out_wait;
    int          out_draw;
    t_row        rows[$];

    circular_path_velocity dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_of(int idx);
        longint t[24] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1,
                          1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        return t[idx];
    endfunction

    // Predicts the velocity command from both positions, the axis and the registers.
    function automatic logic [18:0] velocity_of(logic [23:0] px, logic [23:0] py,
                                                logic [1:0] axis);
        longint r;
        longint dx;
        longint dy;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint len;
        longint q;
        longint vel;
        logic [15:0] phi;
        bit flip;
        r = longint'(radius_q);
        if (r == 0) r = 1;
        if (axis != cpv_pkg::AXIS_X && axis != cpv_pkg::AXIS_Y) return '0;
        dx = longint'(signed'(px)) - longint'(signed'(cen_x_q));
        dy = longint'(signed'(py)) - longint'(signed'(cen_y_q));
        x = dx * 256;
        y = dy * 256;
        z = 0;
        flip = 1'b0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32768;
        end
        if (dx != 0 || dy != 0) begin
            for (int i = 0; i < cpv_pkg::NSTEP; i++) begin
                xs = floor_sh(x, i);
                ys = floor_sh(y, i);
                if (y >= 0) begin
                    x = x + ys; y = y - xs; z += atan_of(i);
                end else begin
                    x = x - ys; y = y + xs; z -= atan_of(i);
                end
            end
            len = (floor_sh(x, 8) * 10187607 + (64'sd1 <<< 23)) >>> 24;
        end else begin
            z = 0;
            len = 0;
        end
        // SV signed division truncates toward zero, as wanted.
        q = ((len - r) * 42722830) / (r * 4096);
        phi = 16'(z + q);
        z = longint'(signed'(phi));
        if (z > 16384) begin
            z -= 32768; flip = 1'b1;
        end else if (z < -16384) begin
            z += 32768; flip = 1'b1;
        end
        x = (r * 10187607 + (64'sd1 <<< 15)) >>> 16;
        y = 0;
        for (int i = 0; i < cpv_pkg::NSTEP; i++) begin
            xs = floor_sh(x, i);
            ys = floor_sh(y, i);
            if (z >= 0) begin
                x = x - ys; y = y + xs; z -= atan_of(i);
            end else begin
                x = x + ys; y = y - xs; z += atan_of(i);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        vel = (axis == cpv_pkg::AXIS_X) ? (-y) / 5120 : x / 5120;
        return 19'(vel);
    endfunction

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // APB write: setup cycle, then access cycle; the caller releases the bus.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            cpv_pkg::REG_RADIUS:   radius_q = value[cpv_pkg::RAD_W-1:0];
            cpv_pkg::REG_CENTRE_X: cen_x_q  = value[cpv_pkg::CEN_W-1:0];
            cpv_pkg::REG_CENTRE_Y: cen_y_q  = value[cpv_pkg::CEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic setup(logic [31:0] rad, logic [31:0] cx, logic [31:0] cy);
        write_reg(cpv_pkg::REG_RADIUS, rad);
        write_reg(cpv_pkg::REG_CENTRE_X, cx);
        write_reg(cpv_pkg::REG_CENTRE_Y, cy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sends one transaction after a random gap; the expectation is queued on acceptance.
    task automatic send_item(logic [23:0] px, logic [23:0] py, logic [1:0] axis,
                             bit fixed, logic [18:0] cmd);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        s_axis_tuser  <= axis;
        do @(posedge i_clk); while (!s_axis_tready);
        exp_cmds.insert(exp_cmds.size(), fixed ? cmd : velocity_of(px, py, axis));
        n_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (exp_cmds.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_pos(logic [23:0] centre, int span);
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) return 24'($urandom);
        if (mode == 1) return centre;
        return centre + 24'($urandom_range(0, 2 * span) - span);
    endfunction

    // Output side: random back-pressure before each result is taken, and in-order comparison.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            out_wait      <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (exp_cmds.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, '0);
                end else begin
                    logic [18:0] want;
                    want = exp_cmds.pop_front();
                    if (m_axis_tdata[18:0] !== want)
                        report_mismatch("velocity_cmd", {5'b0, m_axis_tdata[18:0]},
                                        {5'b0, want});
                    if (m_axis_tdata[23:19] !== 5'b0)
                        report_mismatch("pad bits", m_axis_tdata, {5'b0, want});
                    n_checked++;
                end
                out_draw = $urandom_range(0, 3);
                out_wait      <= out_draw;
                m_axis_tready <= (out_draw == 0);
            end else if (out_wait > 0) begin
                out_wait      <= out_wait - 1;
                m_axis_tready <= (out_wait == 1);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", exp_cmds.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int span;
        int r;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        idle_count = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        radius_q = cpv_pkg::RADIUS_RST;
        cen_x_q  = cpv_pkg::CENTRE_RST;
        cen_y_q  = cpv_pkg::CENTRE_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on reset registers: other axes give zero, the rest is predicted.
        rows = '{
            '{24'd400000, 24'd300000, 2'd2, 1'b1, 19'd0},
            '{24'h7FFFFF, 24'h800000, 2'd3, 1'b1, 19'd0},
            '{24'd400000, 24'd300000, cpv_pkg::AXIS_X, 1'b0, 19'd0},
            '{24'd400000, 24'd300000, cpv_pkg::AXIS_Y, 1'b0, 19'd0},
            '{24'd300000, 24'd400000, cpv_pkg::AXIS_X, 1'b0, 19'd0},
            '{24'd200000, 24'd300000, cpv_pkg::AXIS_Y, 1'b0, 19'd0},
            '{24'd300000, 24'd200000, cpv_pkg::AXIS_X, 1'b0, 19'd0},
            '{24'd300000, 24'd300000, cpv_pkg::AXIS_X, 1'b0, 19'd0},
            '{24'd300000, 24'd300000, cpv_pkg::AXIS_Y, 1'b0, 19'd0},
            '{24'h7FFFFF, 24'h7FFFFF, cpv_pkg::AXIS_X, 1'b0, 19'd0},
            '{24'h800000, 24'h800000, cpv_pkg::AXIS_Y, 1'b0, 19'd0},
            '{24'h800000, 24'h7FFFFF, cpv_pkg::AXIS_X, 1'b0, 19'd0},
            '{24'h7FFFFF, 24'h800000, cpv_pkg::AXIS_Y, 1'b0, 19'd0},
            '{24'd0, 24'd0, cpv_pkg::AXIS_X, 1'b0, 19'd0},
            '{24'd370711, 24'd370711, cpv_pkg::AXIS_Y, 1'b0, 19'd0}
        };
        foreach (rows[k]) send_item(rows[k].px, rows[k].py, rows[k].axis,
                                    rows[k].fixed, rows[k].cmd);
        wait_drained();

        // Extreme registers: zero radius, largest radius, centres at both ends.
        setup(32'd0, 32'h800000, 32'h7FFFFF);
        send_item(24'h800000, 24'h7FFFFF, cpv_pkg::AXIS_X, 1'b0, 19'd0);
        send_item(24'h7FFFFF, 24'h800000, cpv_pkg::AXIS_Y, 1'b0, 19'd0);
        send_item(24'h800001, 24'h7FFFFF, cpv_pkg::AXIS_Y, 1'b0, 19'd0);
        wait_drained();
        setup(32'h3FFFFF, 32'h7FFFFF, 32'h800000);
        send_item(24'h800000, 24'h7FFFFF, cpv_pkg::AXIS_X, 1'b0, 19'd0);
        send_item(24'h7FFFFF, 24'h800000, cpv_pkg::AXIS_Y, 1'b0, 19'd0);
        send_item(24'h400000, 24'h000000, cpv_pkg::AXIS_X, 1'b0, 19'd0);
        wait_drained();

        // Random phases: mostly points in a box around the circle, some at the centre, some anywhere.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: r = 1;
                1: r = 4194303;
                2: r = 100000;
                default: r = $urandom_range(1, 4194303);
            endcase
            if (ph == 2) setup(r, 300000, 300000);
            else setup(r, $urandom, $urandom);
            span = (r < 1000) ? 2000 : r + r / 4;
            for (int k = 0; k < RANDOM_ITEMS / 8; k++)
                send_item(rand_pos(cen_x_q, span), rand_pos(cen_y_q, span),
                          ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                      : 2'($urandom_range(0, 1)),
                          1'b0, 19'd0);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d transactions over %0d register settings; %0d results checked.",
                 n_sent, 11, n_checked);
        if (errors == 0 && exp_cmds.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, exp_cmds.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
